FILE: hdl/pip_pkg.sv
`timescale 1ns / 1ps

package pip_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DET_W      = PROD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int VCOUNT_W   = 3;
    localparam int REACH_W    = 31;
    localparam int EDGE_COUNT = 4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DET_W-1:0]   det_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } orient_t;

    typedef struct packed {
        logic crossed;
        logic decided;
        logic on_edge;
    } edge_res_t;

    typedef struct packed {
        logic [VCOUNT_W-1:0]   vertex_count;
        logic [CFG_DATA_W-1:0] vertex_a;
        logic [CFG_DATA_W-1:0] vertex_b;
        logic [CFG_DATA_W-1:0] vertex_c;
        logic [CFG_DATA_W-1:0] vertex_d;
        logic [CFG_DATA_W-1:0] origin_offset;
        logic [REACH_W-1:0]    ray_reach;
    } cfg_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERTEX_COUNT  = 3'd0,
        REG_VERTEX_A      = 3'd1,
        REG_VERTEX_B      = 3'd2,
        REG_VERTEX_C      = 3'd3,
        REG_VERTEX_D      = 3'd4,
        REG_ORIGIN_OFFSET = 3'd5,
        REG_RAY_REACH     = 3'd6
    } cfg_reg_t;

    localparam logic [VCOUNT_W-1:0] VCOUNT_TRIANGLE = 3'd3;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET    = 3'd4;
    localparam logic [REACH_W-1:0]  REACH_RESET     = 31'd25600000;

    // v lies between a and b, inclusive, in either order
    function automatic logic in_span(input coord_t v, input coord_t a, input coord_t b);
        coord_t lo;
        coord_t hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic orient_t orient_of_det(input det_t d);
        orient_t o;
        o.zero = (d == '0);
        o.neg  = d[DET_W-1];
        return o;
    endfunction

    // sign of -(dx * dy): orientation against the horizontal ray
    function automatic orient_t orient_of_ray(input diff_t dx, input diff_t dy);
        orient_t o;
        o.zero = (dx == '0) || (dy == '0);
        o.neg  = !o.zero && (dx[DIFF_W-1] == dy[DIFF_W-1]);
        return o;
    endfunction

endpackage

FILE: hdl/pip_cfg_regs.sv
`timescale 1ns / 1ps

module pip_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pip_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pip_pkg::cfg_t                    cfg
);
    import pip_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_VERTEX_COUNT:  cfg_next.vertex_count  = cfg_data[VCOUNT_W-1:0];
                REG_VERTEX_A:      cfg_next.vertex_a      = cfg_data;
                REG_VERTEX_B:      cfg_next.vertex_b      = cfg_data;
                REG_VERTEX_C:      cfg_next.vertex_c      = cfg_data;
                REG_VERTEX_D:      cfg_next.vertex_d      = cfg_data;
                REG_ORIGIN_OFFSET: cfg_next.origin_offset = cfg_data;
                REG_RAY_REACH:     cfg_next.ray_reach     = cfg_data[REACH_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vertex_count  <= VCOUNT_RESET;
            cfg_reg.vertex_a      <= '0;
            cfg_reg.vertex_b      <= '0;
            cfg_reg.vertex_c      <= '0;
            cfg_reg.vertex_d      <= '0;
            cfg_reg.origin_offset <= '0;
            cfg_reg.ray_reach     <= REACH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/pip_edge.sv
`timescale 1ns / 1ps

module pip_edge (
    input  logic                clk,
    input  pip_pkg::point_t     e0,
    input  pip_pkg::point_t     e1,
    input  pip_pkg::point_t     p,
    input  pip_pkg::coord_t     fx,
    output pip_pkg::edge_res_t  res
);
    import pip_pkg::*;

    diff_t edge_dx;
    diff_t edge_dy;
    diff_t pt_dx;
    diff_t far_dx;
    diff_t pt_dy;
    diff_t ray_dx;
    diff_t e0_dy;
    diff_t e1_dy;

    prod_t   prod_a_next, prod_b_next, prod_c_next;
    prod_t   prod_a_reg,  prod_b_reg,  prod_c_reg;
    orient_t o3_next, o4_next, o3_reg, o4_reg;
    logic    box_p_next, box_far_next, box_e0_next, box_e1_next;
    logic    box_p_reg,  box_far_reg,  box_e0_reg,  box_e1_reg;

    orient_t o1;
    orient_t o2;
    logic    meet;

    always_comb
    begin
        edge_dx = diff_t'(e1.x) - diff_t'(e0.x);
        edge_dy = diff_t'(e1.y) - diff_t'(e0.y);
        pt_dx   = diff_t'(p.x)  - diff_t'(e1.x);
        far_dx  = diff_t'(fx)   - diff_t'(e1.x);
        pt_dy   = diff_t'(p.y)  - diff_t'(e1.y);
        ray_dx  = diff_t'(fx)   - diff_t'(p.x);
        e0_dy   = diff_t'(e0.y) - diff_t'(p.y);
        e1_dy   = diff_t'(e1.y) - diff_t'(p.y);

        prod_a_next = edge_dy * pt_dx;
        prod_b_next = edge_dy * far_dx;
        prod_c_next = edge_dx * pt_dy;

        o3_next = orient_of_ray(ray_dx, e0_dy);
        o4_next = orient_of_ray(ray_dx, e1_dy);

        box_p_next   = in_span(p.x, e0.x, e1.x) && in_span(p.y, e0.y, e1.y);
        box_far_next = in_span(fx, e0.x, e1.x) && in_span(p.y, e0.y, e1.y);
        box_e0_next  = in_span(e0.x, p.x, fx) && (e0.y == p.y);
        box_e1_next  = in_span(e1.x, p.x, fx) && (e1.y == p.y);
    end

    always_ff @(posedge clk)
    begin
        prod_a_reg  <= prod_a_next;
        prod_b_reg  <= prod_b_next;
        prod_c_reg  <= prod_c_next;
        o3_reg      <= o3_next;
        o4_reg      <= o4_next;
        box_p_reg   <= box_p_next;
        box_far_reg <= box_far_next;
        box_e0_reg  <= box_e0_next;
        box_e1_reg  <= box_e1_next;
    end

    // o1: point against edge, o2: ray end against edge; they share the C product
    always_comb
    begin
        o1 = orient_of_det(det_t'(prod_a_reg) - det_t'(prod_c_reg));
        o2 = orient_of_det(det_t'(prod_b_reg) - det_t'(prod_c_reg));

        meet = ((o1 != o2) && (o3_reg != o4_reg))
            || (o1.zero && box_p_reg)
            || (o2.zero && box_far_reg)
            || (o3_reg.zero && box_e0_reg)
            || (o4_reg.zero && box_e1_reg);

        res.crossed = meet && !o1.zero;
        res.decided = meet && o1.zero;
        res.on_edge = box_p_reg;
    end

endmodule

FILE: hdl/point_in_polygon_ray_cast.sv
`timescale 1ns / 1ps

// Point-in-polygon test over a configured triangle or quadrilateral, Q24.8 coordinates.
// One query point is taken in every cycle (busy is always low) and its answer appears
// on inside_res with a one-cycle done strobe once through the pipeline. The pipeline has three
// register stages: the offset point, the edge cross products (twelve 33x33 multipliers,
// three per edge), and the result. There is no output buffering: done and inside_res
// are valid for that single cycle only and the receiver must take them then.
// Configuration writes are applied at once; write them only while no query is in flight.

module point_in_polygon_ray_cast #(
    parameter int COORD_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [31:0]               point_x,
    input  logic signed [31:0]               point_y,
    output logic                             done,
    output logic                             inside_res,
    input  logic                             cfg_we,
    input  logic [pip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pip_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pip_pkg::*;

    function automatic coord_t sext(input logic [COORD_W-1:0] v);
        return coord_t'(signed'(v[COORD_BITS-1:0]));
    endfunction

    cfg_t      cfg;
    point_t    va, vb, vc, vd;
    coord_t    fx;
    logic      tri_mode;
    logic      accept;

    logic [COORD_BITS-1:0] sum_x;
    logic [COORD_BITS-1:0] sum_y;
    point_t    p_next;
    point_t    p_reg;
    logic      s1_valid_reg;
    logic      s2_valid_reg;
    logic      done_reg;
    logic      inside_next;
    logic      inside_reg;

    point_t    e0 [EDGE_COUNT];
    point_t    e1 [EDGE_COUNT];
    edge_res_t eres [EDGE_COUNT];
    logic [EDGE_COUNT-1:0] active;

    pip_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        va.x = sext(cfg.vertex_a[63:32]);
        va.y = sext(cfg.vertex_a[31:0]);
        vb.x = sext(cfg.vertex_b[63:32]);
        vb.y = sext(cfg.vertex_b[31:0]);
        vc.x = sext(cfg.vertex_c[63:32]);
        vc.y = sext(cfg.vertex_c[31:0]);
        vd.x = sext(cfg.vertex_d[63:32]);
        vd.y = sext(cfg.vertex_d[31:0]);
        fx   = coord_t'({1'b0, cfg.ray_reach});
        tri_mode = (cfg.vertex_count == VCOUNT_TRIANGLE);

        e0[0] = va;  e1[0] = vb;
        e0[1] = vb;  e1[1] = vc;
        e0[2] = vc;  e1[2] = tri_mode ? va : vd;
        e0[3] = va;  e1[3] = vd;
        active = {!tri_mode, 3'b111};
    end

    assign accept = start && !busy;
    assign busy   = 1'b0;

    // offset add wraps to the coordinate width
    always_comb
    begin
        sum_x = point_x[COORD_BITS-1:0] + cfg.origin_offset[32 +: COORD_BITS];
        sum_y = point_y[COORD_BITS-1:0] + cfg.origin_offset[0 +: COORD_BITS];
        p_next.x = coord_t'(signed'(sum_x));
        p_next.y = coord_t'(signed'(sum_y));
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    for (genvar i = 0; i < EDGE_COUNT; i++)
    begin : g_edge
        pip_edge u_edge (
            .clk (clk),
            .e0  (e0[i]),
            .e1  (e1[i]),
            .p   (p_reg),
            .fx  (fx),
            .res (eres[i])
        );
    end

    // first collinear crossed edge decides, otherwise crossing parity
    always_comb
    begin
        logic found;
        logic parity;
        logic decided_val;
        found       = 1'b0;
        parity      = 1'b0;
        decided_val = 1'b0;
        for (int i = 0; i < EDGE_COUNT; i++)
        begin
            if (active[i] && !found)
            begin
                if (eres[i].decided)
                begin
                    found       = 1'b1;
                    decided_val = eres[i].on_edge;
                end
                else
                begin
                    parity = parity ^ eres[i].crossed;
                end
            end
        end
        inside_next = found ? decided_val : parity;
    end

    always_ff @(posedge clk)
    begin
        inside_reg <= inside_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;

    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##2 done)
        else $error("accepted transaction did not complete after three cycles");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s1_valid_reg, 2) && $past(s2_valid_reg, 1))
        else $error("done strobe without a transaction in the pipeline");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(inside_res))
        else $error("result unknown while done is high");

endmodule
